// ===== rtl/gnms_pkg.sv =====
// Shared types and constants for the greedy suppression box selector.
`default_nettype none
package gnms_pkg;

  localparam int unsigned GeomW = 62;
  localparam int unsigned ScoreW = 16;
  localparam int unsigned ThrW = 16;
  localparam int unsigned ModeW = 2;
  localparam int unsigned IdxW = 6;

  // Configuration register indexes.
  localparam logic [0:0] CfgThreshold = 1'b0;
  localparam logic [0:0] CfgMode = 1'b1;

  // Denominator selections.
  localparam logic [1:0] ModeUnion = 2'd0;
  localparam logic [1:0] ModeLarger = 2'd1;
  localparam logic [1:0] ModeSmaller = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // write the input beat into the stores
    logic scan_start;  // clear best-so-far before a maximum scan
    logic scan_rd;     // read entry at scan index for the maximum search
    logic kill_best;   // clear the alive flag of the pick, latch its geometry
    logic sup_rd;      // read entry at scan index for the overlap test
    logic clear_all;   // drop every alive flag and the count at run end
  } gnms_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic found;
    logic sup_busy;    // overlap pipeline still holds work
  } gnms_sts_t;

endpackage
`default_nettype wire

// ===== rtl/gnms_datapath.sv =====
// Box stores, maximum search and the pipelined overlap test.
`default_nettype none
module gnms_datapath #(
  parameter int unsigned MAX_BOXES = 64,
  parameter int unsigned CntW = 7,
  parameter int unsigned AW = 6
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire gnms_pkg::gnms_cmd_t       cmd,
  input  wire logic [AW-1:0]             scan_idx,
  input  wire logic [gnms_pkg::GeomW-1:0] in_geom,
  input  wire logic [gnms_pkg::ScoreW-1:0] in_score,
  input  wire logic [gnms_pkg::ThrW-1:0] thr,
  input  wire logic [gnms_pkg::ModeW-1:0] mode,
  output logic [CntW-1:0]                count,
  output logic [AW-1:0]                  best_idx,
  output gnms_pkg::gnms_sts_t            sts
);

  logic [gnms_pkg::GeomW-1:0]  geom_mem [MAX_BOXES];
  logic [gnms_pkg::ScoreW-1:0] score_mem [MAX_BOXES];
  logic [MAX_BOXES-1:0] alive_r;
  logic [CntW-1:0] count_r;

  assign count = count_r;
  assign sts.full = (count_r == CntW'(MAX_BOXES));

  // Read address: the pick's own entry while it is being killed, else the scan index.
  logic [AW-1:0] best_idx_r;
  logic [AW-1:0] rd_addr;
  assign rd_addr = cmd.kill_best ? best_idx_r : scan_idx;

  // Registered reads of the stores.
  logic [gnms_pkg::GeomW-1:0]  geom_rd_r;
  logic [gnms_pkg::ScoreW-1:0] score_rd_r;
  logic [AW-1:0] rd_idx_r;
  logic scan_v_r, sup_v_r;
  always_ff @(posedge clk) begin
    if (cmd.load && !sts.full) begin
      geom_mem[count_r[AW-1:0]] <= in_geom;
      score_mem[count_r[AW-1:0]] <= in_score;
    end
    geom_rd_r <= geom_mem[rd_addr];
    score_rd_r <= score_mem[rd_addr];
    rd_idx_r <= rd_addr;
  end

  // Maximum search, later index wins on equal scores.
  logic best_v_r;
  logic [gnms_pkg::ScoreW-1:0] best_score_r;
  assign best_idx = best_idx_r;
  assign sts.found = best_v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_v_r <= 1'b0;
    end else if (cmd.scan_start) begin
      best_v_r <= 1'b0;
    end else if (scan_v_r && alive_r[rd_idx_r] &&
                 (!best_v_r || score_rd_r >= best_score_r)) begin
      best_v_r <= 1'b1;
      best_score_r <= score_rd_r;
      best_idx_r <= rd_idx_r;
    end
  end

  // Pick geometry, fetched when the pick is killed.
  logic [gnms_pkg::GeomW-1:0] pick_r;
  logic pick_ld_r;
  always_ff @(posedge clk) begin
    if (pick_ld_r) pick_r <= geom_rd_r;
  end

  // Stage 1: intersection extents and box sizes.
  function automatic logic signed [17:0] sx(input logic [15:0] v);
    sx = 18'(signed'(v));
  endfunction
  logic signed [17:0] ax, ay, aw, ah, bx, by, bw, bh;
  logic signed [17:0] x1, x2, y1, y2, iw, ih;
  always_comb begin
    ax = sx(geom_rd_r[15:0]);
    ay = sx(geom_rd_r[31:16]);
    aw = 18'(geom_rd_r[46:32]);
    ah = 18'(geom_rd_r[61:47]);
    bx = sx(pick_r[15:0]);
    by = sx(pick_r[31:16]);
    bw = 18'(pick_r[46:32]);
    bh = 18'(pick_r[61:47]);
    x1 = (ax > bx) ? ax : bx;
    x2 = ((ax + aw) < (bx + bw)) ? (ax + aw) : (bx + bw);
    y1 = (ay > by) ? ay : by;
    y2 = ((ay + ah) < (by + bh)) ? (ay + ah) : (by + bh);
    iw = x2 - x1;
    ih = y2 - y1;
  end

  logic s1_v_r, s1_ov_r;
  logic [AW-1:0] s1_idx_r;
  logic [16:0] s1_iw_r, s1_ih_r;
  logic [14:0] s1_aw_r, s1_ah_r, s1_bw_r, s1_bh_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= sup_v_r && alive_r[rd_idx_r];
    end
    s1_ov_r <= (iw > 18'sd0) && (ih > 18'sd0);
    s1_idx_r <= rd_idx_r;
    s1_iw_r <= iw[16:0];
    s1_ih_r <= ih[16:0];
    s1_aw_r <= geom_rd_r[46:32];
    s1_ah_r <= geom_rd_r[61:47];
    s1_bw_r <= pick_r[46:32];
    s1_bh_r <= pick_r[61:47];
  end

  // Stage 2: the three products.
  logic s2_v_r, s2_ov_r;
  logic [AW-1:0] s2_idx_r;
  logic [33:0] s2_inter_r;
  logic [29:0] s2_area_a_r, s2_area_b_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
    s2_ov_r <= s1_ov_r;
    s2_idx_r <= s1_idx_r;
    s2_inter_r <= 34'(s1_iw_r) * 34'(s1_ih_r);
    s2_area_a_r <= 30'(s1_aw_r) * 30'(s1_ah_r);
    s2_area_b_r <= 30'(s1_bw_r) * 30'(s1_bh_r);
  end

  // Stage 3: denominator.
  logic [30:0] denom;
  always_comb begin
    case (mode)
      gnms_pkg::ModeLarger:
        denom = 31'((s2_area_a_r > s2_area_b_r) ? s2_area_a_r : s2_area_b_r);
      gnms_pkg::ModeSmaller:
        denom = 31'((s2_area_a_r < s2_area_b_r) ? s2_area_a_r : s2_area_b_r);
      default:
        denom = 31'(34'(s2_area_a_r) + 34'(s2_area_b_r) - s2_inter_r);
    endcase
  end
  logic s3_v_r, s3_ov_r;
  logic [AW-1:0] s3_idx_r;
  logic [33:0] s3_inter_r;
  logic [30:0] s3_denom_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v_r;
    end
    s3_ov_r <= s2_ov_r;
    s3_idx_r <= s2_idx_r;
    s3_inter_r <= s2_inter_r;
    s3_denom_r <= denom;
  end

  // Stage 4: threshold product, then compare.
  logic s4_v_r, s4_ov_r;
  logic [AW-1:0] s4_idx_r;
  logic [33:0] s4_inter_r;
  logic [46:0] s4_rhs_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else begin
      s4_v_r <= s3_v_r;
    end
    s4_ov_r <= s3_ov_r;
    s4_idx_r <= s3_idx_r;
    s4_inter_r <= s3_inter_r;
    s4_rhs_r <= 47'(s3_denom_r) * 47'(thr);
  end
  logic kill_sup;
  assign kill_sup = s4_v_r && s4_ov_r && ({s4_inter_r[30:0], 16'h0} > s4_rhs_r);

  assign sts.sup_busy = sup_v_r || s1_v_r || s2_v_r || s3_v_r || s4_v_r;

  // Alive flags and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alive_r <= '0;
      count_r <= '0;
      scan_v_r <= 1'b0;
      sup_v_r <= 1'b0;
      pick_ld_r <= 1'b0;
    end else begin
      scan_v_r <= cmd.scan_rd;
      sup_v_r <= cmd.sup_rd;
      pick_ld_r <= cmd.kill_best;
      if (cmd.clear_all) begin
        alive_r <= '0;
        count_r <= '0;
      end else begin
        if (cmd.load && !sts.full) begin
          alive_r[count_r[AW-1:0]] <= 1'b1;
          count_r <= count_r + CntW'(1);
        end
        if (cmd.kill_best) alive_r[best_idx_r] <= 1'b0;
        if (kill_sup) alive_r[s4_idx_r] <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/gnms_ctrl.sv =====
// Controller: load, maximum scan, result beat and suppression sweep.
`default_nettype none
module gnms_ctrl #(
  parameter int unsigned CntW = 7,
  parameter int unsigned AW = 6
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic                in_last,
  input  wire logic                out_busy,
  output logic                     out_push,
  output logic                     out_last,
  input  wire logic [CntW-1:0]     count,
  input  wire gnms_pkg::gnms_sts_t sts,
  output gnms_pkg::gnms_cmd_t      cmd,
  output logic [AW-1:0]            scan_idx
);

  typedef enum logic [5:0] {
    S_LOAD = 6'b000001,
    S_SCAN = 6'b000010,
    S_WAIT = 6'b000100,
    S_EMIT = 6'b001000,
    S_SUP  = 6'b010000,
    S_DRAIN = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [CntW-1:0] idx_r, idx_nxt;
  logic held_r, held_nxt;  // a pick waits for the next scan to learn if it is last
  logic [1:0] wait_r, wait_nxt;

  assign scan_idx = idx_r[AW-1:0];

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    held_nxt = held_r;
    wait_nxt = wait_r;
    cmd = '0;
    in_tready = 1'b0;
    out_push = 1'b0;
    out_last = 1'b0;
    case (state_r)
      S_LOAD: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            state_nxt = S_SCAN;
            idx_nxt = '0;
            cmd.scan_start = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (idx_r == count) begin
          state_nxt = S_WAIT;
          wait_nxt = 2'd2;
        end else begin
          cmd.scan_rd = 1'b1;
          idx_nxt = idx_r + CntW'(1);
        end
      end
      S_WAIT: begin
        if (wait_r != 2'd0) begin
          wait_nxt = wait_r - 2'd1;
        end else if (!out_busy) begin
          // Emit the held pick now that we know whether another follows.
          if (held_r) begin
            out_push = 1'b1;
            out_last = !sts.found;
          end
          held_nxt = 1'b0;
          if (sts.found) begin
            state_nxt = S_EMIT;
          end else begin
            cmd.clear_all = 1'b1;
            state_nxt = S_LOAD;
          end
        end
      end
      S_EMIT: begin
        cmd.kill_best = 1'b1;
        held_nxt = 1'b1;
        idx_nxt = '0;
        state_nxt = S_SUP;
      end
      S_SUP: begin
        if (idx_r == count) begin
          state_nxt = S_DRAIN;
        end else begin
          cmd.sup_rd = 1'b1;
          idx_nxt = idx_r + CntW'(1);
        end
      end
      S_DRAIN: begin
        if (!sts.sup_busy) begin
          cmd.scan_start = 1'b1;
          idx_nxt = '0;
          state_nxt = S_SCAN;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      idx_r <= '0;
      held_r <= 1'b0;
      wait_r <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      held_r <= held_nxt;
      wait_r <= wait_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/greedy_nms_box_selector_core.sv =====
// Top level of the greedy suppression box selector.
// Boxes arrive one per beat on in_; while loading, one is stored per cycle.
// The beat with in_tlast set starts greedy suppression over the stored set;
// no input is taken until every kept index has been sent on out_, the final
// one with out_tlast. Each pick costs a scan over the N stored boxes plus a
// suppression sweep over them through a five-stage overlap pipeline. Boxes
// beyond MAX_BOXES are dropped. A single output register holds the result
// beat; while it is pending and out_tready is low, the controller waits
// before the next pick.
// Configuration beats on cfg_ are always accepted and must arrive only when
// the block is idle. Reset empties the set, sets the threshold to one half
// and the overlap measure to the union.
`default_nettype none
module greedy_nms_box_selector_core #(
  parameter int unsigned MAX_BOXES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // box_x[15:0], box_y[31:16], box_width[46:32], box_height[61:47],
  // box_score[77:62], zero [79:78]
  input  wire logic [79:0] in_tdata,
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // picked_index[5:0], zero [7:6]
  output logic [7:0]       out_tdata,
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int unsigned CntW = $clog2(MAX_BOXES + 1);
  localparam int unsigned AW = $clog2(MAX_BOXES);

  // Configuration registers.
  logic [gnms_pkg::ThrW-1:0] thr_r;
  logic [gnms_pkg::ModeW-1:0] mode_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 16'h8000;
      mode_r <= gnms_pkg::ModeUnion;
    end else if (cfg_valid) begin
      case (cfg_index)
        gnms_pkg::CfgThreshold: thr_r <= cfg_data;
        gnms_pkg::CfgMode: mode_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  gnms_pkg::gnms_cmd_t cmd;
  gnms_pkg::gnms_sts_t sts;
  logic [CntW-1:0] count;
  logic [AW-1:0] scan_idx, best_idx;
  logic out_push, out_last;

  gnms_datapath #(.MAX_BOXES(MAX_BOXES), .CntW(CntW), .AW(AW)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .scan_idx(scan_idx),
    .in_geom(in_tdata[61:0]), .in_score(in_tdata[77:62]),
    .thr(thr_r), .mode(mode_r), .count(count), .best_idx(best_idx), .sts(sts)
  );

  gnms_ctrl #(.CntW(CntW), .AW(AW)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_last(in_tlast), .out_busy(out_tvalid && !out_tready),
    .out_push(out_push), .out_last(out_last), .count(count), .sts(sts),
    .cmd(cmd), .scan_idx(scan_idx)
  );

  // Index of the pick held until the following scan decides last.
  logic [AW-1:0] pick_idx_r;
  always_ff @(posedge clk) begin
    if (cmd.kill_best) pick_idx_r <= best_idx;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (out_push) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (out_push) begin
      out_tdata <= 8'(pick_idx_r);
      out_tlast <= out_last;
    end
  end

endmodule
`default_nettype wire

// ===== test/greedy_nms_box_selector_core_checker.sv =====
// Checker for the suppression box selector: predicts kept indexes and compares them.
`timescale 1ns / 100ps
`default_nettype none
module greedy_nms_box_selector_core_checker #(
  parameter int unsigned MAX_BOXES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [79:0] in_tdata,
  input  wire logic        in_tlast,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [7:0]  out_tdata,
  input  wire logic        out_tlast,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output int               fail_count,
  output int               pending_picks,
  output int               picks_seen,
  output int               sets_seen
);

  typedef struct packed {
    logic [5:0] index;
    logic       last;
  } pick_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
  } box_t;

  box_t        boxes[MAX_BOXES];
  logic [15:0] scores[MAX_BOXES];
  bit          alive[MAX_BOXES];
  int          stored;
  logic [15:0] thr;
  logic [1:0]  mode;
  pick_t       kept_q[$];

  assign pending_picks = kept_q.size();

  // True when box a overlaps the pick b by more than the threshold.
  function automatic bit overlaps_pick(box_t a, box_t b);
    longint x1, x2, y1, y2, iw, ih, inter, aa, ab, den;
    x1 = (a.x > b.x) ? a.x : b.x;
    x2 = ((a.x + longint'(a.w)) < (b.x + longint'(b.w))) ?
         a.x + longint'(a.w) : b.x + longint'(b.w);
    y1 = (a.y > b.y) ? a.y : b.y;
    y2 = ((a.y + longint'(a.h)) < (b.y + longint'(b.h))) ?
         a.y + longint'(a.h) : b.y + longint'(b.h);
    iw = x2 - x1;
    ih = y2 - y1;
    if (iw <= 0 || ih <= 0) return 0;
    inter = iw * ih;
    aa = longint'(a.w) * longint'(a.h);
    ab = longint'(b.w) * longint'(b.h);
    if (mode == gnms_pkg::ModeLarger) den = (aa > ab) ? aa : ab;
    else if (mode == gnms_pkg::ModeSmaller) den = (aa < ab) ? aa : ab;
    else den = aa + ab - inter;
    return (inter << 16) > longint'(thr) * den;
  endfunction

  // Greedy selection over the stored set; queues every kept index.
  task automatic select_boxes();
    int best, n;
    bit found;
    pick_t p;
    n = 0;
    forever begin
      found = 0;
      best = 0;
      for (int i = 0; i < stored; i++)
        if (alive[i] && (!found || scores[i] >= scores[best])) begin
          best = i;
          found = 1;
        end
      if (!found) break;
      alive[best] = 0;
      p.index = best[5:0];
      p.last = 1'b0;
      kept_q = {kept_q, p};
      n++;
      for (int i = 0; i < stored; i++)
        if (alive[i] && overlaps_pick(boxes[i], boxes[best])) alive[i] = 0;
    end
    if (n > 0) kept_q[$].last = 1'b1;
    for (int i = 0; i < MAX_BOXES; i++) alive[i] = 0;
    stored = 0;
  endtask

  task automatic report(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    pick_t want;
    if (!rst_n) begin
      stored = 0;
      thr = 16'd32768;
      mode = gnms_pkg::ModeUnion;
      for (int i = 0; i < MAX_BOXES; i++) alive[i] = 0;
      kept_q.delete();
      fail_count = 0;
      picks_seen = 0;
      sets_seen = 0;
    end else begin
      // Result beats are checked before a new set can be predicted.
      if (out_tvalid && out_tready) begin
        picks_seen++;
        if (kept_q.size() == 0) begin
          report("unexpected beat index", out_tdata[5:0], -1);
        end else begin
          want = kept_q.pop_front();
          if (out_tdata[5:0] != want.index) report("index", out_tdata[5:0], want.index);
          if (out_tlast != want.last) report("last flag", out_tlast, want.last);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == gnms_pkg::CfgThreshold) thr = cfg_data;
        else mode = cfg_data[1:0];
      end
      if (in_tvalid && in_tready) begin
        if (stored < MAX_BOXES) begin
          boxes[stored] = '{x: in_tdata[15:0], y: in_tdata[31:16],
                            w: in_tdata[46:32], h: in_tdata[61:47]};
          scores[stored] = in_tdata[77:62];
          alive[stored] = 1;
          stored++;
        end
        if (in_tlast) begin
          sets_seen++;
          select_boxes();
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== test/greedy_nms_box_selector_core_tb.sv =====
// Testbench top for the suppression box selector: stimulus, back-pressure and verdict.
`timescale 1ns / 100ps
`default_nettype none
module greedy_nms_box_selector_core_tb;

  localparam int unsigned MAX_BOXES = 64;
  localparam int LIMIT = 3_000_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = gnms_pkg::CfgThreshold;
  logic [15:0] cfg_data = '0;

  int fail_count, pending_picks, picks_seen, sets_seen;
  int cycles = 0;
  int boxes_sent = 0;
  bit long_hold = 0;
  bit sink_on = 1;

  greedy_nms_box_selector_core #(.MAX_BOXES(MAX_BOXES)) dut (.*);

  greedy_nms_box_selector_core_checker #(.MAX_BOXES(MAX_BOXES)) checker_i (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Cycle counter guards against a hung block.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("greedy_nms_box_selector_core regression: fail");
      $finish;
    end
  end

  // Random short and occasional long gaps.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result receiver: random stalls when sink_on is set, plus a long hold-off that recurs.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (long_hold) begin
      out_tready <= 1'b0;
    end else if (sink_on) begin
      out_tready <= ($urandom_range(0, 3) != 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    wait (rst_n);
    forever begin
      repeat ($urandom_range(2000, 4000)) @(posedge clk);
      long_hold = 1;
      repeat (600) @(posedge clk);
      long_hold = 0;
      repeat ($urandom_range(20000, 40000)) @(posedge clk);
    end
  end

  task automatic send_box(logic signed [15:0] x, logic signed [15:0] y,
                          logic [14:0] w, logic [14:0] h,
                          logic [15:0] s, logic last);
    int g;
    g = gap_len();
    repeat (g) begin
      @(posedge clk);
      in_tvalid <= 1'b0;
    end
    @(posedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, s, h, w, y, x};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    in_tvalid <= 1'b0;
    boxes_sent++;
    // Put the falling valid into effect before any later drive.
    #0;
  endtask

  // Back-to-back sender that keeps valid high across beats.
  task automatic send_burst(int n, bit cluster);
    logic signed [15:0] cx, cy;
    cx = 16'($urandom);
    cy = 16'($urandom);
    @(posedge clk);
    for (int i = 0; i < n; i++) begin
      in_tvalid <= 1'b1;
      if (cluster)
        in_tdata <= {2'b00, 16'($urandom_range(0, 7) * 4096), 15'($urandom_range(20, 60)),
                     15'($urandom_range(20, 60)), 16'(cy + $urandom_range(0, 30)),
                     16'(cx + $urandom_range(0, 30))};
      else
        in_tdata <= {2'b00, 16'($urandom), 15'($urandom_range(1, 32767)),
                     15'($urandom_range(1, 32767)), 16'($urandom), 16'($urandom)};
      in_tlast <= (i == n - 1);
      do @(posedge clk); while (!in_tready);
      boxes_sent++;
    end
    in_tvalid <= 1'b0;
  endtask

  // Lets the checker predict the last set, then waits until every pick is out.
  task automatic wait_idle();
    @(posedge clk);
    while (pending_picks != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // A random set of boxes, mostly clustered so suppression has work to do.
  task automatic random_set(int n);
    logic signed [15:0] cx, cy;
    logic [15:0] s;
    bit cl;
    cl = ($urandom_range(0, 3) != 0);
    cx = 16'($urandom);
    cy = 16'($urandom);
    for (int i = 0; i < n; i++) begin
      s = ($urandom_range(0, 4) == 0) ? 16'h8000 : 16'($urandom);
      if (cl)
        send_box(16'(cx + $urandom_range(0, 40)), 16'(cy + $urandom_range(0, 40)),
                 15'($urandom_range(10, 80)), 15'($urandom_range(10, 80)), s, i == n - 1);
      else
        send_box(16'($urandom), 16'($urandom), 15'($urandom_range(1, 32767)),
                 15'($urandom_range(1, 32767)), s, i == n - 1);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: extremes, equal scores, touching and disjoint boxes, default setting.
    send_box(-16'sd32768, -16'sd32768, 15'd32767, 15'd32767, 16'hFFFF, 1'b0);
    send_box(16'sd32767, 16'sd32767, 15'd1, 15'd1, 16'h0000, 1'b0);
    send_box(-16'sd32768, -16'sd32768, 15'd32767, 15'd32767, 16'hFFFF, 1'b0);
    send_box(16'sd0, 16'sd0, 15'd10, 15'd10, 16'h1000, 1'b0);
    send_box(16'sd10, 16'sd0, 15'd10, 15'd10, 16'h1000, 1'b0);
    send_box(16'sd2, 16'sd2, 15'd10, 15'd10, 16'h0FFF, 1'b1);
    wait_idle();
    // A single box set.
    send_box(16'sd5, -16'sd5, 15'd3, 15'd3, 16'h0001, 1'b1);
    wait_idle();
    // Every mode, including the unused one; modes 0 and 3 get extreme thresholds.
    for (int m = 0; m < 4; m++) begin
      write_reg(gnms_pkg::CfgMode, 16'(m));
      write_reg(gnms_pkg::CfgThreshold,
                (m == 3) ? 16'hFFFF : (m == 0 ? 16'h0000 : 16'h4000));
      send_box(16'sd0, 16'sd0, 15'd20, 15'd20, 16'h9000, 1'b0);
      send_box(16'sd5, 16'sd5, 15'd20, 15'd20, 16'h8000, 1'b0);
      send_box(16'sd0, 16'sd0, 15'd20, 15'd20, 16'h9000, 1'b1);
      wait_idle();
    end

    // Overfill: the set is capped and the marked box beyond it is dropped.
    write_reg(gnms_pkg::CfgMode, 16'(gnms_pkg::ModeUnion));
    write_reg(gnms_pkg::CfgThreshold, 16'd32768);
    send_burst(MAX_BOXES + 3, 1'b1);
    wait_idle();

    // Random sets under changing settings, with a back-to-back burst of 2 to 20 boxes now and then.
    while (boxes_sent < 260) begin
      if ($urandom_range(0, 3) == 0) begin
        wait_idle();
        write_reg(gnms_pkg::CfgThreshold,
                  ($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom));
        write_reg(gnms_pkg::CfgMode, 16'($urandom_range(0, 3)));
      end
      sink_on = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 9) == 0)
        send_burst($urandom_range(2, 20), 1'($urandom_range(0, 1)));
      else random_set($urandom_range(1, 8));
      // Now and then the sender pauses until every pick has come out.
      if ($urandom_range(0, 5) == 0) wait_idle();
    end

    wait_idle();
    $display("covered %0d boxes in %0d sets, %0d picks checked over all overlap modes",
             boxes_sent, sets_seen, picks_seen);
    if (fail_count == 0 && pending_picks == 0) begin
      $display("greedy_nms_box_selector_core regression: pass");
    end else begin
      $display("greedy_nms_box_selector_core regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/gnms_pkg.sv
rtl/gnms_datapath.sv
rtl/gnms_ctrl.sv
rtl/greedy_nms_box_selector_core.sv
test/greedy_nms_box_selector_core_checker.sv
test/greedy_nms_box_selector_core_tb.sv
